FILE: hw/rtl/icalc_pkg.sv
package icalc_pkg;

    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_MUL  = 2'd1;
    localparam logic [1:0] MUL_DIV  = 2'd2;

    localparam logic [59:0] SAT_MANT = {60{1'b1}};
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX  = 64'h8000_0000_0000_0000;

    typedef logic [67:0] t_pow;

    function automatic t_pow f_pow10(input logic [4:0] k);
        t_pow p;
        case (k)
            5'd0:    p = 68'd1;
            5'd1:    p = 68'd10;
            5'd2:    p = 68'd100;
            5'd3:    p = 68'd1000;
            5'd4:    p = 68'd10000;
            5'd5:    p = 68'd100000;
            5'd6:    p = 68'd1000000;
            5'd7:    p = 68'd10000000;
            5'd8:    p = 68'd100000000;
            5'd9:    p = 68'd1000000000;
            5'd10:   p = 68'd10000000000;
            5'd11:   p = 68'd100000000000;
            5'd12:   p = 68'd1000000000000;
            5'd13:   p = 68'd10000000000000;
            5'd14:   p = 68'd100000000000000;
            5'd15:   p = 68'd1000000000000000;
            5'd16:   p = 68'd10000000000000000;
            5'd17:   p = 68'd100000000000000000;
            5'd18:   p = 68'd1000000000000000000;
            5'd19:   p = 68'd10000000000000000000;
            5'd20:   p = 68'd100000000000000000000;
            default: p = 68'd0;
        endcase
        return p;
    endfunction

    function automatic logic [63:0] f_mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

FILE: hw/rtl/infix_calculator_with_percent.sv
// Channel   | Dir | tdata                    | tuser                          | tlast
// s_axis    | in  | [7:0] char_code          | -                              | last_char
// m_axis    | out | [63:0] result_value      | [0] div_by_zero, [1] overflow  | -
//
// A digit, dot or ignored character goes through S_IDLE, S_DISP and S_TASK in turn.
// Each number end, unless saturated, runs a shift-subtract divide; a pending '*'
// adds a shift-add multiply, a pending '/' with a nonzero divisor another divide,
// and a percent fold one more multiply. All iterate on one shared 128-bit datapath.
// Reset is synchronous active low; it clears the sequencer but not the datapath.
// The result sits in an output register; input is taken while it waits, but the
// next result stalls until it is taken.
module infix_calculator_with_percent
    import icalc_pkg::*;
#(
    parameter int FRAC_BITS  = 32,
    parameter int MAX_DIGITS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] result_value
    output logic [1:0]  m_axis_tuser    // [0] div_by_zero, [1] overflow
);

    localparam int         DIV_ITER = 64 + FRAC_BITS;
    localparam logic [63:0] DIG_LIMIT = 64'(f_pow10(5'(MAX_DIGITS)));
    localparam logic [4:0]  MAXD     = 5'(MAX_DIGITS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_TASK  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_POST  = 4'd5;
    localparam logic [3:0] S_APPLY = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;

    localparam logic [1:0] K_NUM  = 2'd0;
    localparam logic [1:0] K_TERM = 2'd1;
    localparam logic [1:0] K_FOLD = 2'd2;

    logic [3:0]   r_state;
    logic [7:0]   r_char;
    logic         r_t_end, r_t_mul, r_t_fold, r_t_add, r_t_out, r_pct;
    logic [63:0]  r_sum, r_term, r_v;
    logic         r_term_pct, r_term_started, r_sum_started, r_add_op;
    logic [1:0]   r_mul_op;
    logic [59:0]  r_mant;
    logic [4:0]   r_fdig;
    logic         r_present, r_fraction, r_frozen;
    logic         r_err_div, r_err_ovf;
    logic [127:0] r_acc;
    logic [67:0]  r_rem, r_opd;
    logic [6:0]   r_cnt;
    logic         r_neg, r_is_mul;
    logic [1:0]   r_kind;
    logic         r_out_valid;
    logic [63:0]  r_out_data;
    logic [1:0]   r_out_user;

    logic         w_is_digit;
    logic [3:0]   w_digit;
    logic [63:0]  w_grown;
    logic [68:0]  w_rem_sh;
    logic         w_ge;
    logic [64:0]  w_mac;
    logic [127:0] w_mag;
    logic [63:0]  w_lim;
    logic         w_over;
    logic [63:0]  w_sat;
    logic [63:0]  w_addsub;
    logic         w_add_ovf;
    logic         w_out_load;

    assign w_is_digit = (r_char >= CH_0) && (r_char <= CH_9);
    assign w_digit    = 4'(r_char - CH_0);
    assign w_grown    = {1'b0, r_mant, 3'b0} + {3'b0, r_mant, 1'b0} + {60'd0, w_digit};

    assign w_rem_sh = {r_rem, r_acc[127]};
    assign w_ge     = w_rem_sh >= {1'b0, r_opd};
    assign w_mac    = {1'b0, r_acc[127:64]} + (r_acc[0] ? {1'b0, r_opd[63:0]} : 65'd0);

    assign w_mag  = r_is_mul ? (r_acc >> FRAC_BITS) : r_acc;
    assign w_lim  = r_neg ? NEG_MAX : POS_MAX;
    assign w_over = (|w_mag[127:64]) || (w_mag[63:0] > w_lim);
    assign w_sat  = w_over ? w_lim : (r_neg ? (64'd0 - w_mag[63:0]) : w_mag[63:0]);

    assign w_out_load = (r_state == S_TASK) && !r_t_end && !r_t_mul && !r_t_fold
                        && !r_t_add && r_t_out && (!r_out_valid || m_axis_tready);

    always_comb begin
        if (r_add_op) begin
            w_addsub  = r_sum - r_v;
            w_add_ovf = (r_sum[63] != r_v[63]) && (w_addsub[63] != r_sum[63]);
        end else begin
            w_addsub  = r_sum + r_v;
            w_add_ovf = (r_sum[63] == r_v[63]) && (w_addsub[63] != r_sum[63]);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_t_end        <= 1'b0;
            r_t_mul        <= 1'b0;
            r_t_fold       <= 1'b0;
            r_t_add        <= 1'b0;
            r_t_out        <= 1'b0;
            r_sum          <= '0;
            r_term         <= '0;
            r_term_pct     <= 1'b0;
            r_term_started <= 1'b0;
            r_sum_started  <= 1'b0;
            r_add_op       <= 1'b0;
            r_mul_op       <= MUL_NONE;
            r_mant         <= '0;
            r_fdig         <= '0;
            r_present      <= 1'b0;
            r_fraction     <= 1'b0;
            r_frozen       <= 1'b0;
            r_err_div      <= 1'b0;
            r_err_ovf      <= 1'b0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_char  <= s_axis_tdata;
                        r_t_out <= s_axis_tlast;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_pct    <= (r_char == CH_PERCENT);
                    r_t_end  <= r_t_out || (r_char == CH_PERCENT) || (r_char == CH_STAR)
                                || (r_char == CH_SLASH) || (r_char == CH_PLUS)
                                || (r_char == CH_MINUS);
                    r_t_mul  <= (r_char == CH_STAR) || (r_char == CH_SLASH);
                    r_t_fold <= r_t_out || (r_char == CH_PLUS) || (r_char == CH_MINUS);
                    r_t_add  <= (r_char == CH_PLUS) || (r_char == CH_MINUS);
                    if (w_is_digit && !r_frozen) begin
                        r_present <= 1'b1;
                        if (r_fraction) begin
                            if (r_fdig >= MAXD || w_grown >= DIG_LIMIT) begin
                                r_err_ovf <= 1'b1;
                            end else begin
                                r_mant <= w_grown[59:0];
                                r_fdig <= r_fdig + 5'd1;
                            end
                        end else if (w_grown >= DIG_LIMIT) begin
                            r_err_ovf <= 1'b1;
                            r_mant    <= SAT_MANT;
                            r_fdig    <= '0;
                            r_frozen  <= 1'b1;
                        end else begin
                            r_mant <= w_grown[59:0];
                        end
                    end else if (r_char == CH_DOT && !r_frozen) begin
                        if (r_fraction) begin
                            r_frozen <= 1'b1;
                        end else begin
                            r_fraction <= 1'b1;
                            r_present  <= 1'b1;
                        end
                    end
                    r_state <= S_TASK;
                end
                S_TASK: begin
                    if (r_t_end) begin
                        if (!r_present) begin
                            r_t_end <= 1'b0;
                        end else if (r_mant == SAT_MANT) begin
                            r_err_ovf <= 1'b1;
                            r_v       <= POS_MAX;
                            r_state   <= S_APPLY;
                        end else begin
                            r_acc    <= {4'b0, r_mant, 64'b0};
                            r_opd    <= f_pow10(r_fdig + (r_pct ? 5'd2 : 5'd0));
                            r_rem    <= '0;
                            r_cnt    <= 7'(DIV_ITER);
                            r_neg    <= 1'b0;
                            r_is_mul <= 1'b0;
                            r_kind   <= K_NUM;
                            r_state  <= S_DIV;
                        end
                    end else if (r_t_mul) begin
                        r_mul_op <= (r_char == CH_STAR) ? MUL_MUL : MUL_DIV;
                        r_t_mul  <= 1'b0;
                    end else if (r_t_fold) begin
                        r_mul_op <= MUL_NONE;
                        if (!r_term_started) begin
                            r_t_fold <= 1'b0;
                        end else if (r_term_pct && r_sum_started) begin
                            r_acc    <= {64'b0, f_mag(r_term)};
                            r_opd    <= {4'b0, f_mag(r_sum)};
                            r_cnt    <= 7'd64;
                            r_neg    <= r_sum[63] ^ r_term[63];
                            r_is_mul <= 1'b1;
                            r_kind   <= K_FOLD;
                            r_state  <= S_MUL;
                        end else begin
                            r_v     <= r_term;
                            r_state <= S_ADD;
                        end
                    end else if (r_t_add) begin
                        r_add_op <= (r_char == CH_MINUS);
                        r_t_add  <= 1'b0;
                    end else if (r_t_out) begin
                        if (!r_out_valid || m_axis_tready) begin
                            r_out_data     <= r_sum;
                            r_out_user     <= {r_err_ovf, r_err_div};
                            r_t_out        <= 1'b0;
                            r_sum          <= '0;
                            r_term         <= '0;
                            r_term_pct     <= 1'b0;
                            r_term_started <= 1'b0;
                            r_sum_started  <= 1'b0;
                            r_add_op       <= 1'b0;
                            r_mul_op       <= MUL_NONE;
                            r_mant         <= '0;
                            r_fdig         <= '0;
                            r_present      <= 1'b0;
                            r_fraction     <= 1'b0;
                            r_frozen       <= 1'b0;
                            r_err_div      <= 1'b0;
                            r_err_ovf      <= 1'b0;
                            r_state        <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem   <= w_ge ? 68'(w_rem_sh - {1'b0, r_opd}) : w_rem_sh[67:0];
                    r_acc   <= {r_acc[126:0], w_ge};
                    r_cnt   <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_POST;
                    end
                end
                S_MUL: begin
                    r_acc <= {w_mac, r_acc[63:1]};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (w_over) begin
                        r_err_ovf <= 1'b1;
                    end
                    unique case (r_kind)
                        K_NUM: begin
                            r_v     <= w_sat;
                            r_state <= S_APPLY;
                        end
                        K_TERM: begin
                            r_term         <= w_sat;
                            r_term_pct     <= 1'b0;
                            r_term_started <= 1'b1;
                            r_mul_op       <= MUL_NONE;
                            r_mant         <= '0;
                            r_fdig         <= '0;
                            r_present      <= 1'b0;
                            r_fraction     <= 1'b0;
                            r_frozen       <= 1'b0;
                            r_t_end        <= 1'b0;
                            r_state        <= S_TASK;
                        end
                        default: begin
                            r_v     <= w_sat;
                            r_state <= S_ADD;
                        end
                    endcase
                end
                S_APPLY: begin
                    if (r_mul_op == MUL_MUL) begin
                        r_acc    <= {64'b0, f_mag(r_v)};
                        r_opd    <= {4'b0, f_mag(r_term)};
                        r_cnt    <= 7'd64;
                        r_neg    <= r_term[63] ^ r_v[63];
                        r_is_mul <= 1'b1;
                        r_kind   <= K_TERM;
                        r_state  <= S_MUL;
                    end else if (r_mul_op == MUL_DIV && r_v != 64'd0) begin
                        r_acc    <= {f_mag(r_term), 64'b0};
                        r_opd    <= {4'b0, f_mag(r_v)};
                        r_rem    <= '0;
                        r_cnt    <= 7'(DIV_ITER);
                        r_neg    <= r_term[63] ^ r_v[63];
                        r_is_mul <= 1'b0;
                        r_kind   <= K_TERM;
                        r_state  <= S_DIV;
                    end else begin
                        if (r_mul_op == MUL_DIV) begin
                            r_err_div      <= 1'b1;
                            r_term         <= '0;
                            r_term_pct     <= 1'b0;
                            r_term_started <= 1'b1;
                            r_mul_op       <= MUL_NONE;
                        end else if (!r_term_started) begin
                            r_term         <= r_v;
                            r_term_pct     <= r_pct;
                            r_term_started <= 1'b1;
                        end
                        r_mant     <= '0;
                        r_fdig     <= '0;
                        r_present  <= 1'b0;
                        r_fraction <= 1'b0;
                        r_frozen   <= 1'b0;
                        r_t_end    <= 1'b0;
                        r_state    <= S_TASK;
                    end
                end
                S_ADD: begin
                    if (w_add_ovf) begin
                        r_err_ovf <= 1'b1;
                        r_sum     <= r_sum[63] ? NEG_MAX : POS_MAX;
                    end else begin
                        r_sum <= w_addsub;
                    end
                    r_sum_started  <= 1'b1;
                    r_term         <= '0;
                    r_term_pct     <= 1'b0;
                    r_term_started <= 1'b0;
                    r_t_fold       <= 1'b0;
                    r_state        <= S_TASK;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_iter_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_MUL) |-> (r_cnt != 7'd0))
        else $error("iteration counter empty while unit busy");

    a_frac_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fdig <= MAXD)
        else $error("fraction digit count beyond limit");

    a_mant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({4'b0, r_mant} < DIG_LIMIT) || (r_mant == SAT_MANT))
        else $error("mantissa out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("result lost while stalled");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import icalc_pkg::*;

    localparam int FRAC    = 32;
    localparam int MAXDIG  = 18;
    localparam int WD_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_code
    logic        s_axis_tlast = 1'b0;   // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // [63:0] result_value
    logic [1:0]  m_axis_tuser;          // [0] div_by_zero, [1] overflow

    always #1 i_clk = ~i_clk;

    infix_calculator_with_percent dut (.*);

    typedef struct packed {
        logic [63:0] value;
        logic        dbz;
        logic        ovf;
    } calc_res_t;

    // calculator state
    logic [63:0] sum_q, term_q;
    logic        term_pct, term_on, sum_on, sub_op;
    logic [1:0]  mul_op;
    logic [63:0] mant;
    int          fdig;
    logic        n_present, n_frac, n_frozen;
    logic        err_dbz, err_ovf;

    calc_res_t   results_due[$];
    int          errors = 0;
    int          beats_in = 0, beats_out = 0;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_recv = 1'b0;
    int          quiet = 0;
    int          n_dbz = 0, n_ovf = 0;

    function automatic logic [63:0] pow10(int k);
        logic [63:0] p = 64'd1;
        for (int i = 0; i < k; i++) p = p * 10;
        return p;
    endfunction

    function automatic logic [63:0] magn(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] clamp(bit neg, logic [127:0] m);
        logic [63:0] lim;
        lim = neg ? NEG_MAX : POS_MAX;
        if (m > {64'd0, lim}) begin
            err_ovf = 1'b1;
            return lim;
        end
        return neg ? -m[63:0] : m[63:0];
    endfunction

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        return clamp(a[63] ^ b[63], p >> FRAC);
    endfunction

    function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
        logic [127:0] n;
        if (b == 0) begin
            err_dbz = 1'b1;
            return 64'd0;
        end
        n = {64'd0, magn(a)} << FRAC;
        return clamp(a[63] ^ b[63], n / {64'd0, magn(b)});
    endfunction

    function automatic logic [63:0] fx_addsub(logic [63:0] a, logic [63:0] b, bit sub);
        logic [63:0] s;
        bit same;
        s = sub ? a - b : a + b;
        same = sub ? (a[63] != b[63]) : (a[63] == b[63]);
        if (same && (s[63] != a[63])) begin
            err_ovf = 1'b1;
            return a[63] ? NEG_MAX : POS_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] num_value(bit pct);
        logic [63:0] p, ip, r, fr, rest;
        logic [127:0] t;
        if (mant == {4'd0, SAT_MANT}) begin
            err_ovf = 1'b1;
            return POS_MAX;
        end
        p = pow10(fdig);
        ip = mant / p;
        r = mant % p;
        fr = 64'd0;
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            fr = fr << 1;
            if (r >= p) begin
                r = r - p;
                fr[0] = 1'b1;
            end
        end
        if (pct) begin
            rest = ip % 100;
            ip = ip / 100;
            t = ({64'd0, rest} << FRAC) | {64'd0, fr};
            fr = t / 100;
        end
        if (ip >= (64'd1 << (63 - FRAC))) begin
            err_ovf = 1'b1;
            return POS_MAX;
        end
        return (ip << FRAC) | fr;
    endfunction

    task automatic calc_clear();
        sum_q = 0; term_q = 0; term_pct = 0; term_on = 0; sum_on = 0;
        sub_op = 0; mul_op = MUL_NONE; mant = 0; fdig = 0;
        n_present = 0; n_frac = 0; n_frozen = 0; err_dbz = 0; err_ovf = 0;
    endtask

    task automatic close_number(bit pct);
        logic [63:0] v;
        if (!n_present) return;
        v = num_value(pct);
        if (mul_op == MUL_MUL || mul_op == MUL_DIV) begin
            term_q = (mul_op == MUL_MUL) ? fx_mul(term_q, v) : fx_div(term_q, v);
            term_pct = 0;
            term_on = 1;
            mul_op = MUL_NONE;
        end else if (!term_on) begin
            term_q = v;
            term_pct = pct;
            term_on = 1;
        end
        mant = 0; fdig = 0; n_present = 0; n_frac = 0; n_frozen = 0;
    endtask

    task automatic fold_into_sum();
        logic [63:0] nx;
        mul_op = MUL_NONE;
        if (!term_on) return;
        nx = (term_pct && sum_on) ? fx_mul(sum_q, term_q) : term_q;
        sum_q = fx_addsub(sum_q, nx, sub_op);
        sum_on = 1; term_q = 0; term_pct = 0; term_on = 0;
    endtask

    task automatic push_digit(int d);
        logic [63:0] grown;
        if (n_frozen) return;
        n_present = 1;
        grown = mant * 10 + d;
        if (n_frac) begin
            if (fdig >= MAXDIG || grown >= pow10(MAXDIG)) begin
                err_ovf = 1;
                return;
            end
            mant = grown;
            fdig++;
        end else if (grown >= pow10(MAXDIG)) begin
            err_ovf = 1;
            mant = {4'd0, SAT_MANT};
            fdig = 0;
            n_frozen = 1;
        end else begin
            mant = grown;
        end
    endtask

    // advances the calculator by one character; returns 1 with a result on last
    task automatic calc_char(input logic [7:0] c, input bit last,
                             output bit has_res, output calc_res_t res);
        has_res = 0;
        res = '0;
        if (c >= CH_0 && c <= CH_9) begin
            push_digit(c - CH_0);
        end else if (c == CH_DOT) begin
            if (!n_frozen) begin
                if (n_frac) n_frozen = 1;
                else begin
                    n_frac = 1;
                    n_present = 1;
                end
            end
        end else if (c == CH_PERCENT) begin
            close_number(1);
        end else if (c == CH_STAR || c == CH_SLASH) begin
            close_number(0);
            mul_op = (c == CH_STAR) ? MUL_MUL : MUL_DIV;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            close_number(0);
            fold_into_sum();
            sub_op = (c == CH_MINUS);
        end
        if (last) begin
            close_number(0);
            fold_into_sum();
            res.value = sum_q;
            res.dbz = err_dbz;
            res.ovf = err_ovf;
            has_res = 1;
            calc_clear();
        end
    endtask

    // typed-in checks on top of the predictor for directed rows
    task automatic send_char(logic [7:0] c, bit last, bit chk = 0,
                             calc_res_t want = '0);
        bit h;
        calc_res_t r;
        calc_char(c, last, h, r);
        if (h) begin
            if (chk && r !== want) begin
                $display("%0t directed row: expected %h/%b/%b got predictor %h/%b/%b",
                         $time, want.value, want.dbz, want.ovf, r.value, r.dbz, r.ovf);
                errors++;
            end
            results_due.push_back(r);
        end
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_in++;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send_expr(string s, bit chk = 0, calc_res_t want = '0);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1, chk, want);
    endtask

    function automatic string rand_number();
        string s = "";
        int n = $urandom_range(100) < 5 ? $urandom_range(19, 24) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
        if ($urandom_range(3) == 0) begin
            s = {s, "."};
            n = $urandom_range(100) < 5 ? $urandom_range(15, 22) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
        end
        if ($urandom_range(30) == 0) s = {s, ".7"};
        if ($urandom_range(8) == 0) s = {s, "%"};
        return s;
    endfunction

    function automatic string rand_expr();
        string s = "";
        string ops = "+-*/";
        int nt = $urandom_range(1, 4);
        if ($urandom_range(7) == 0) s = "-";
        for (int i = 0; i < nt; i++) begin
            if (i > 0) s = {s, string'(ops[$urandom_range(3)])};
            if ($urandom_range(20) == 0) s = {s, "0"};
            else s = {s, rand_number()};
        end
        return s;
    endfunction

    // noise: any byte at all, last set at random and always on the final byte
    task automatic send_noise(int n);
        for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(255)), $urandom_range(5) == 0);
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(int sidle, int rstall, int nitems);
        int start;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        start = beats_in;
        while (beats_in - start < nitems) begin
            if ($urandom_range(9) == 0) send_noise($urandom_range(1, 6));
            else send_expr(rand_expr());
        end
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (hold_recv) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        calc_res_t w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (results_due.size() == 0) begin
                $display("%0t unexpected result %h tuser %b", $time, m_axis_tdata,
                         m_axis_tuser);
                errors++;
            end else begin
                w = results_due.pop_front();
                n_dbz += w.dbz;
                n_ovf += w.ovf;
                if (m_axis_tdata !== w.value) begin
                    $display("%0t value: expected %h actual %h", $time, w.value,
                             m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== w.dbz) begin
                    $display("%0t div_by_zero: expected %b actual %b", $time, w.dbz,
                             m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== w.ovf) begin
                    $display("%0t overflow: expected %b actual %b", $time, w.ovf,
                             m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("%0t watchdog: no progress, %0d results outstanding", $time,
                     results_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    typedef struct {
        string     expr;
        bit        chk;
        calc_res_t want;
    } stim_row_t;

    stim_row_t rows[] = '{
        '{"7", 1, '{64'h0000_0007_0000_0000, 0, 0}},
        '{"0", 1, '{64'd0, 0, 0}},
        '{"9/0", 1, '{64'd0, 1, 0}},
        '{"100-10%", 1, '{64'h0000_005A_0000_003C, 0, 0}},
        '{"2+3*4", 1, '{64'h0000_000E_0000_0000, 0, 0}},
        '{"-5", 1, '{64'hFFFF_FFFB_0000_0000, 0, 0}},
        '{"1234567890123456789", 1, '{POS_MAX, 0, 1}},
        '{"2147483648", 1, '{POS_MAX, 0, 1}},
        '{"2147483647.5", 1, '{64'h7FFF_FFFF_8000_0000, 0, 0}},
        '{"1.5.9", 0, '{64'd0, 0, 0}},
        '{".", 1, '{64'd0, 0, 0}},
        '{"%", 1, '{64'd0, 0, 0}},
        '{"50%", 1, '{64'h0000_0000_8000_0000, 0, 0}},
        '{"0.1234567890123456789", 0, '{64'd0, 0, 0}},
        '{"8/3", 0, '{64'd0, 0, 0}},
        '{"-7/2", 0, '{64'd0, 0, 0}},
        '{"3 4", 0, '{64'd0, 0, 0}},
        '{"*5", 0, '{64'd0, 0, 0}},
        '{"6*/2", 0, '{64'd0, 0, 0}},
        '{"6*+2", 0, '{64'd0, 0, 0}},
        '{"2000000000*2000000000", 1, '{POS_MAX, 0, 1}},
        '{"-2000000000-2000000000", 1, '{NEG_MAX, 0, 1}},
        '{"1.0000001*3-x12%", 0, '{64'd0, 0, 0}},
        '{"1e3?", 0, '{64'd0, 0, 0}}
    };

    initial begin
        calc_clear();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) send_expr(rows[i].expr, rows[i].chk, rows[i].want);
        drain();

        run_phase(0, 0, 120);
        run_phase(57, 0, 200);
        run_phase(0, 57, 200);

        // long receiver hold while characters keep flowing
        hold_recv = 1'b1;
        fork
            begin
                repeat (3000) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            begin
                run_phase(0, 0, 60);
                drain();
            end
        join

        run_phase(10, 10, 200);
        drain();
        repeat (300) @(negedge i_clk);

        $display("Ran %0d characters, %0d results (%0d with divide-by-zero, %0d overflow)",
                 beats_in, beats_out, n_dbz, n_ovf);
        $display("over directed corner rows and random expressions with idle/stall phases");
        if (errors == 0 && results_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
